### sv/owm_pkg.sv
// owm_pkg: shared types and constants for the 1-wire bus master timing block
// no dependencies; used by owm_core and onewire_master_timing
package owm_pkg;

    // request kinds carried on s_tuser
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

    // field widths
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 64;
    localparam int SLOT_W  = 10;

    // input tdata layout: bit_count, write_data, line_in
    localparam int S_TDATA_W = 72;
    // output tdata layout: drive_low, busy_res, done_res, presence, read_data, rejected
    localparam int M_TDATA_W = 72;

    // slot timing in microseconds
    localparam logic [SLOT_W-1:0] RST_LOW      = 10'd500;
    localparam logic [SLOT_W-1:0] RST_SAMPLE   = 10'd580;
    localparam logic [SLOT_W-1:0] RST_END      = 10'd1000;
    localparam logic [SLOT_W-1:0] RD_LOW       = 10'd3;
    localparam logic [SLOT_W-1:0] RD_SAMPLE    = 10'd13;
    localparam logic [SLOT_W-1:0] RD_END       = 10'd66;
    localparam logic [SLOT_W-1:0] WR1_LOW      = 10'd10;
    localparam logic [SLOT_W-1:0] WR1_END      = 10'd65;
    localparam logic [SLOT_W-1:0] WR0_LOW      = 10'd65;
    localparam logic [SLOT_W-1:0] WR0_END      = 10'd70;

    // one result item
    typedef struct packed {
        logic              rejected;
        logic [DATA_W-1:0] read_data;
        logic              presence;
        logic              done_res;
        logic              busy_res;
        logic              drive_low;
    } result_t;

endpackage

### sv/onewire_master_timing.sv
// onewire_master_timing: 1-wire bus master line timing, top level
// depends on owm_pkg and owm_core
// a request is held in the input register, then its result is written into the result register that drives m_tdata
// throughput: one request per cycle while m_tready is high; the input register and the result register
// let a new request enter while a finished result waits for m_tready
// reset: synchronous on aresetn low; both stages empty, bus state idle, all flags clear
module onewire_master_timing #(
    parameter int MAX_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [6:0] bit_count, [70:7] write_data, [71] line_in
    input  logic [owm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  logic [owm_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
    // [67:4] read_data, [68] rejected, [71:69] zero
    output logic [owm_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                            in_valid_reg, in_valid_next;
    logic [owm_pkg::S_TDATA_W-1:0]   in_data_reg;
    logic [owm_pkg::KIND_W-1:0]      in_kind_reg;
    logic                            out_valid_reg, out_valid_next;
    owm_pkg::result_t                out_res_reg;
    owm_pkg::result_t                res_next;
    logic                            s_accept;
    logic                            advance;

    // handshake between the two stages
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // step logic and bus state
    owm_core #(
        .MAX_BITS (MAX_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .kind       (in_kind_reg),
        .bit_count  (in_data_reg[6:0]),
        .write_data (in_data_reg[70:7]),
        .line_in    (in_data_reg[71]),
        .res_next   (res_next)
    );

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = owm_pkg::M_TDATA_W'(out_res_reg);

endmodule

### sv/owm_core.sv
// owm_core: bus master state and the per-item step logic
// depends on owm_pkg; instantiated by onewire_master_timing
module owm_core #(
    parameter int MAX_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [owm_pkg::KIND_W-1:0]    kind,
    input  logic [owm_pkg::COUNT_W-1:0]   bit_count,
    input  logic [owm_pkg::DATA_W-1:0]    write_data,
    input  logic                          line_in,
    output owm_pkg::result_t              res_next
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam int POS_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_READ  = 2'd2,
        PH_WRITE = 2'd3
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [owm_pkg::SLOT_W-1:0] slot_time_reg, slot_time_next;
    logic [CNT_W-1:0]           bits_left_reg, bits_left_next;
    logic [POS_W-1:0]           bit_position_reg, bit_position_next;
    logic [MAX_BITS-1:0]        send_shift_reg, send_shift_next;
    logic [MAX_BITS-1:0]        read_gather_reg, read_gather_next;
    logic                       presence_reg, presence_next;

    logic [owm_pkg::COUNT_W-1:0] count_sat;
    logic [owm_pkg::SLOT_W-1:0]  slot_inc;
    logic [owm_pkg::SLOT_W-1:0]  wr_end;
    logic                        slot_over;
    logic                        done;
    logic                        rej;
    logic                        drive;

    // saturate the bit count
    assign count_sat = (bit_count > owm_pkg::COUNT_W'(MAX_BITS))
                     ? owm_pkg::COUNT_W'(MAX_BITS) : bit_count;
    assign slot_inc  = slot_time_reg + owm_pkg::SLOT_W'(1);
    assign wr_end    = send_shift_reg[0] ? owm_pkg::WR1_END : owm_pkg::WR0_END;

    // next state for one request
    always_comb begin
        phase_next        = phase_reg;
        slot_time_next    = slot_time_reg;
        bits_left_next    = bits_left_reg;
        bit_position_next = bit_position_reg;
        send_shift_next   = send_shift_reg;
        read_gather_next  = read_gather_reg;
        presence_next     = presence_reg;
        done              = 1'b0;
        rej               = 1'b0;
        slot_over         = 1'b0;

        if (kind != owm_pkg::KIND_TICK) begin
            // commands start only from idle
            if (phase_reg != PH_IDLE) begin
                rej = 1'b1;
            end else if (kind == owm_pkg::KIND_RESET) begin
                phase_next     = PH_RESET;
                slot_time_next = '0;
                presence_next  = 1'b0;
            end else begin
                if (kind == owm_pkg::KIND_READ) begin
                    read_gather_next = '0;
                end
                if (count_sat == '0) begin
                    done = 1'b1;
                end else begin
                    phase_next        = (kind == owm_pkg::KIND_READ) ? PH_READ : PH_WRITE;
                    slot_time_next    = '0;
                    bits_left_next    = CNT_W'(count_sat);
                    bit_position_next = '0;
                    send_shift_next   = (kind == owm_pkg::KIND_WRITE)
                                      ? write_data[MAX_BITS-1:0] : '0;
                end
            end
        end else begin
            // microsecond tick advances the slot
            unique case (phase_reg)
                PH_RESET: begin
                    slot_time_next = slot_inc;
                    if (slot_inc == owm_pkg::RST_SAMPLE) begin
                        presence_next = ~line_in;
                    end
                    if (slot_inc >= owm_pkg::RST_END) begin
                        phase_next     = PH_IDLE;
                        slot_time_next = '0;
                        done           = 1'b1;
                    end
                end
                PH_READ: begin
                    slot_time_next = slot_inc;
                    if (slot_inc == owm_pkg::RD_SAMPLE && line_in) begin
                        read_gather_next[bit_position_reg] = 1'b1;
                    end
                    slot_over = (slot_inc >= owm_pkg::RD_END);
                end
                PH_WRITE: begin
                    slot_time_next = slot_inc;
                    if (slot_inc >= wr_end) begin
                        send_shift_next = send_shift_reg >> 1;
                        slot_over       = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // end of a bit slot
            if (slot_over) begin
                bits_left_next    = bits_left_reg - CNT_W'(1);
                bit_position_next = bit_position_reg + POS_W'(1);
                slot_time_next    = '0;
                if (bits_left_next == '0) begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
        end
    end

    // line drive during the following microsecond
    always_comb begin
        unique case (phase_next)
            PH_RESET: drive = (slot_time_next < owm_pkg::RST_LOW);
            PH_READ:  drive = (slot_time_next < owm_pkg::RD_LOW);
            PH_WRITE: drive = (slot_time_next < (send_shift_next[0] ? owm_pkg::WR1_LOW
                                                                    : owm_pkg::WR0_LOW));
            default:  drive = 1'b0;
        endcase
    end

    // result built from the updated state
    always_comb begin
        res_next.drive_low = drive;
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = done;
        res_next.presence  = presence_next;
        res_next.read_data = owm_pkg::DATA_W'(read_gather_next);
        res_next.rejected  = rej;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            slot_time_reg    <= '0;
            bits_left_reg    <= '0;
            bit_position_reg <= '0;
            send_shift_reg   <= '0;
            read_gather_reg  <= '0;
            presence_reg     <= 1'b0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            slot_time_reg    <= slot_time_next;
            bits_left_reg    <= bits_left_next;
            bit_position_reg <= bit_position_next;
            send_shift_reg   <= send_shift_next;
            read_gather_reg  <= read_gather_next;
            presence_reg     <= presence_next;
        end
    end

endmodule

### tb/onewire_master_timing_tb.sv
// onewire_master_timing_tb: self-checking bench for the 1-wire bus master timing block
// depends on owm_pkg and onewire_master_timing; a line tracker class predicts every result
`timescale 1ns / 100ps

module onewire_master_timing_tb;

    localparam int MAX_BITS     = 64;
    localparam int RANDOM_ITEMS = 100;
    localparam int SETTLE_TICKS = 20;

    typedef enum logic [1:0] {BUS_IDLE, BUS_RESET, BUS_READ, BUS_WRITE} bus_phase_t;
    typedef enum int {LINE_HIGH, LINE_LOW, LINE_NOISY} line_mode_t;

    // tracks the bus master state and holds the results still owed by the block
    class owm_line_tracker;
        bus_phase_t         phase;
        logic [9:0]         slot;
        logic [6:0]         bits_left;
        logic [5:0]         bit_pos;
        logic [63:0]        send_bits;
        logic [63:0]        gathered;
        logic               presence_flag;
        owm_pkg::result_t   pending_line_states[$];
        int                 errors;
        int                 results_seen;

        function new();
            phase         = BUS_IDLE;
            slot          = '0;
            bits_left     = '0;
            bit_pos       = '0;
            send_bits     = '0;
            gathered      = '0;
            presence_flag = 1'b0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function int pending();
            return pending_line_states.size();
        endfunction

        // close one bit slot, report whether the whole transfer is over
        function logic close_slot();
            bits_left = bits_left - 7'd1;
            bit_pos   = bit_pos + 6'd1;
            slot      = '0;
            if (bits_left == 7'd0) begin
                phase = BUS_IDLE;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // one request in, the line state and flags that follow it
        function owm_pkg::result_t line_timing_step(logic [1:0] kind, logic [6:0] count_in,
                                                    logic [63:0] wdata, logic line);
            logic [6:0]       count;
            logic [9:0]       low_len;
            logic             done;
            logic             rej;
            owm_pkg::result_t r;
            count = (count_in > MAX_BITS) ? 7'(MAX_BITS) : count_in;
            done  = 1'b0;
            rej   = 1'b0;
            if (kind != owm_pkg::KIND_TICK) begin
                // commands only start from idle
                if (phase != BUS_IDLE) begin
                    rej = 1'b1;
                end else if (kind == owm_pkg::KIND_RESET) begin
                    phase         = BUS_RESET;
                    slot          = '0;
                    presence_flag = 1'b0;
                end else begin
                    if (kind == owm_pkg::KIND_READ) gathered = '0;
                    if (count == 7'd0) begin
                        done = 1'b1;
                    end else begin
                        phase     = (kind == owm_pkg::KIND_READ) ? BUS_READ : BUS_WRITE;
                        slot      = '0;
                        bits_left = count;
                        bit_pos   = '0;
                        send_bits = (kind == owm_pkg::KIND_WRITE) ? wdata : '0;
                    end
                end
            end else if (phase != BUS_IDLE) begin
                // one microsecond passes
                slot = slot + 10'd1;
                case (phase)
                    BUS_RESET: begin
                        if (slot == owm_pkg::RST_SAMPLE) presence_flag = ~line;
                        if (slot >= owm_pkg::RST_END) begin
                            phase = BUS_IDLE;
                            slot  = '0;
                            done  = 1'b1;
                        end
                    end
                    BUS_READ: begin
                        if (slot == owm_pkg::RD_SAMPLE && line) gathered[bit_pos] = 1'b1;
                        if (slot >= owm_pkg::RD_END) done = close_slot();
                    end
                    default: begin
                        if (slot >= (send_bits[0] ? owm_pkg::WR1_END : owm_pkg::WR0_END)) begin
                            send_bits = send_bits >> 1;
                            done      = close_slot();
                        end
                    end
                endcase
            end
            case (phase)
                BUS_RESET: low_len = owm_pkg::RST_LOW;
                BUS_READ:  low_len = owm_pkg::RD_LOW;
                BUS_WRITE: low_len = send_bits[0] ? owm_pkg::WR1_LOW : owm_pkg::WR0_LOW;
                default:   low_len = '0;
            endcase
            r.drive_low = (phase != BUS_IDLE) && (slot < low_len);
            r.busy_res  = (phase != BUS_IDLE);
            r.done_res  = done;
            r.presence  = presence_flag;
            r.read_data = gathered;
            r.rejected  = rej;
            return r;
        endfunction

        function void note_request(logic [1:0] kind, logic [owm_pkg::S_TDATA_W-1:0] word);
            pending_line_states.push_back(
                line_timing_step(kind, word[6:0], word[70:7], word[71]));
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(logic [owm_pkg::M_TDATA_W-1:0] word);
            owm_pkg::result_t got;
            owm_pkg::result_t want;
            if (pending_line_states.size() == 0) begin
                report("result with no request pending");
                return;
            end
            want = pending_line_states.pop_front();
            got  = word[68:0];
            compare_field("drive_low", 64'(got.drive_low), 64'(want.drive_low));
            compare_field("busy_res", 64'(got.busy_res), 64'(want.busy_res));
            compare_field("done_res", 64'(got.done_res), 64'(want.done_res));
            compare_field("presence", 64'(got.presence), 64'(want.presence));
            compare_field("read_data", got.read_data, want.read_data);
            compare_field("rejected", 64'(got.rejected), 64'(want.rejected));
            compare_field("padding", 64'(word[71:69]), 64'd0);
            results_seen++;
        endtask
    endclass

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [owm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [owm_pkg::KIND_W-1:0]    s_tuser  = owm_pkg::KIND_TICK;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [owm_pkg::M_TDATA_W-1:0] m_tdata;

    owm_line_tracker book = new();
    int              burst_left = 0;
    int              ready_mode = 0;
    logic [15:0]     ready_cycle = '0;

    onewire_master_timing #(
        .MAX_BITS(MAX_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watch both handshakes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) book.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) book.check_result(m_tdata);
        end
    end

    // receiver stalls, pattern picked anew whenever the low byte of ready_cycle wraps to zero
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 16'd1;
        if (ready_cycle[7:0] == 8'd0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_cycle[2:0] < 3'd3);
        endcase
    end

    // present one request, in bursts with random gaps between them
    task automatic send_request(input logic [1:0] kind, input logic [6:0] count,
                                input logic [63:0] wdata, input logic line);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {line, wdata, count};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_tick(input logic line);
        send_request(owm_pkg::KIND_TICK, 7'($urandom), {$urandom, $urandom}, line);
    endtask

    // hold off until every owed result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (book.pending() != 0) @(negedge aclk);
        @(posedge aclk);
        burst_left = 0;
    endtask

    // one command and the ticks it needs, with an optional stray command and early cut
    task automatic run_command(input logic [1:0] kind, input logic [6:0] count,
                               input logic [63:0] wdata, input line_mode_t mode,
                               input int stray_at, input int cut, output int counted);
        int   n;
        int   ticks;
        logic line;
        n = (count > MAX_BITS) ? MAX_BITS : count;
        case (kind)
            owm_pkg::KIND_RESET: ticks = owm_pkg::RST_END;
            owm_pkg::KIND_READ:  ticks = n * owm_pkg::RD_END;
            owm_pkg::KIND_WRITE: begin
                ticks = 0;
                for (int i = 0; i < n; i++)
                    ticks += wdata[i] ? owm_pkg::WR1_END : owm_pkg::WR0_END;
            end
            default:    ticks = 0;
        endcase
        ticks = (ticks > cut) ? ticks - cut : 0;
        send_request(kind, count, wdata, 1'($urandom));
        for (int t = 0; t < ticks; t++) begin
            if (t == stray_at)
                send_request(2'($urandom_range(1, 3)), 7'($urandom), {$urandom, $urandom},
                             1'($urandom));
            case (mode)
                LINE_HIGH: line = 1'b1;
                LINE_LOW:  line = 1'b0;
                default:   line = 1'($urandom);
            endcase
            send_tick(line);
        end
        counted = 1 + ticks;
    endtask

    // run limit
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          n;
        int          counted;
        int          pick;
        int          sz;
        int          count;
        int          stray;
        int          cut;
        logic [1:0]  kind;
        logic        pressed;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle ticks, device present, zero counts, busy commands, single-bit slots
        send_tick(1'b0);
        send_tick(1'b1);
        run_command(owm_pkg::KIND_RESET, 7'h7F, '1, LINE_LOW, 300, 0, n);
        run_command(owm_pkg::KIND_READ, 7'd1, '0, LINE_HIGH, 5, 0, n);
        run_command(owm_pkg::KIND_READ, 7'd0, '1, LINE_NOISY, -1, 0, n);
        run_command(owm_pkg::KIND_WRITE, 7'd1, 64'd1, LINE_NOISY, -1, 0, n);
        run_command(owm_pkg::KIND_WRITE, 7'd1, 64'd0, LINE_NOISY, 40, 0, n);
        run_command(owm_pkg::KIND_WRITE, 7'd0, '1, LINE_NOISY, -1, 0, n);
        run_command(owm_pkg::KIND_READ, 7'd1, '1, LINE_LOW, -1, 0, n);
        send_tick(1'b1);
        wait_drained();

        // random: short reads and writes, some stray and cut sequences
        counted = 0;
        pressed = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 15);
            kind  = (pick < 8) ? owm_pkg::KIND_READ : owm_pkg::KIND_WRITE;
            sz    = $urandom_range(0, 19);
            count = (sz == 0) ? 0 : ((sz < 18) ? $urandom_range(1, 3) : $urandom_range(4, 8));
            stray = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 60) : -1;
            cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0;
            run_command(kind, 7'(count), {$urandom, $urandom}, LINE_NOISY, stray, cut, n);
            counted += n;
            repeat ($urandom_range(0, 2)) send_tick(1'($urandom));
            if (!pressed && counted > RANDOM_ITEMS / 2) begin
                wait_drained();
                pressed = 1'b1;
            end
        end

        // let any cut transfer run out, then a reset with no device, stopped after the sample
        repeat (40) send_tick(1'($urandom));
        run_command(owm_pkg::KIND_RESET, 7'd0, '0, LINE_HIGH, -1, 400, n);

        // drain, then give stray results time to show up
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        @(negedge aclk);
        if (book.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
